// ----- src/sse_pkg.sv -----
// Package for the SSE compare/logic/shuffle unit: function codes, predicates, lane helpers.
// No dependencies.
`timescale 1ns / 1ps
package sse_pkg;

    typedef enum logic [3:0] {
        FN_CMPPS   = 4'd0,
        FN_CMPSS   = 4'd1,
        FN_COMISS  = 4'd2,
        FN_UCOMISS = 4'd3,
        FN_AND     = 4'd4,
        FN_ANDN    = 4'd5,
        FN_OR      = 4'd6,
        FN_XOR     = 4'd7,
        FN_SHUF    = 4'd8,
        FN_UNPCKL  = 4'd9,
        FN_UNPCKH  = 4'd10,
        FN_MOVMSK  = 4'd11,
        FN_MOVHL   = 4'd12,
        FN_MOVLH   = 4'd13,
        FN_MOVSS   = 4'd14
    } func_t;

    typedef enum logic [2:0] {
        PR_EQ    = 3'd0,
        PR_LT    = 3'd1,
        PR_LE    = 3'd2,
        PR_UNORD = 3'd3,
        PR_NEQ   = 3'd4,
        PR_NLT   = 3'd5,
        PR_NLE   = 3'd6,
        PR_ORD   = 3'd7
    } pred_t;

    localparam logic [31:0] LANE_SIGN = 32'h8000_0000;
    localparam logic [31:0] LANE_MAG  = 32'h7FFF_FFFF;
    localparam logic [31:0] LANE_INF  = 32'h7F80_0000;
    localparam logic [31:0] LANE_ONES = 32'hFFFF_FFFF;
    localparam logic [1:0]  SEL_MASK  = 2'h3;

    typedef logic [31:0] lane_t;

    // Compare outcome of one lane pair
    typedef struct packed {
        logic un;
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed {
        logic [63:0] r_low;
        logic [63:0] r_high;
        logic [3:0]  sign_mask;
        logic        zero_flag;
        logic        parity_flag;
        logic        carry_flag;
    } result_t;

endpackage

// ----- src/sse_compare_logic_shuffle_unit.sv -----
// Top level of the SSE compare/logic/shuffle unit: input register, datapath, result register.
// Depends on sse_pkg, sse_exec.
`timescale 1ns / 1ps
// One beat in, one beat out. A beat is captured into an input register at the
// accepting edge. It then passes through a single level of compare/select logic
// and lands in a result register when that stage can load; a stalled result
// side holds it back. The unit sustains one beat per cycle while the result side
// is not stalled. The two stages form a pipeline with flow control: each stage
// loads when it is empty or when its contents move on in the same cycle. s_ready
// therefore stays high while the result side is stalled, as long as the input
// stage is free. Undefined func 15 yields an all-zero result.
module sse_compare_logic_shuffle_unit
    import sse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [7:0]  s_imm,
    input  logic [63:0] s_a_low,
    input  logic [63:0] s_a_high,
    input  logic [63:0] s_b_low,
    input  logic [63:0] s_b_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_r_low,
    output logic [63:0] m_r_high,
    output logic [3:0]  m_sign_mask,
    output logic        m_zero_flag,
    output logic        m_parity_flag,
    output logic        m_carry_flag
);
    logic        in_vld_reg;
    logic [3:0]  func_reg;
    logic [7:0]  imm_reg;
    logic [63:0] a_low_reg, a_high_reg, b_low_reg, b_high_reg;
    result_t     res_next, res_reg;
    logic        out_vld_reg;
    logic        out_load, in_load;

    // Result stage frees when empty or drained this cycle
    assign out_load = !out_vld_reg || m_ready;
    assign in_load  = !in_vld_reg || out_load;
    assign s_ready  = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_load) in_vld_reg <= s_valid;
            if (out_load) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            func_reg   <= s_func;
            imm_reg    <= s_imm;
            a_low_reg  <= s_a_low;
            a_high_reg <= s_a_high;
            b_low_reg  <= s_b_low;
            b_high_reg <= s_b_high;
        end
        if (out_load && in_vld_reg) res_reg <= res_next;
    end

    sse_exec u_exec (
        .func   (func_reg),
        .imm    (imm_reg),
        .a_low  (a_low_reg),
        .a_high (a_high_reg),
        .b_low  (b_low_reg),
        .b_high (b_high_reg),
        .res    (res_next)
    );

    assign m_valid       = out_vld_reg;
    assign m_r_low       = res_reg.r_low;
    assign m_r_high      = res_reg.r_high;
    assign m_sign_mask   = res_reg.sign_mask;
    assign m_zero_flag   = res_reg.zero_flag;
    assign m_parity_flag = res_reg.parity_flag;
    assign m_carry_flag  = res_reg.carry_flag;

    // A held result must not be overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_low) && $stable(m_r_high))
        else $error("result changed while stalled");

    // Parity flag only ever comes with zero and carry set
    a_pf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_parity_flag |-> m_zero_flag && m_carry_flag)
        else $error("PF without ZF/CF");

    // Flags and sign mask never appear together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_sign_mask != 4'd0) |-> !m_zero_flag && !m_carry_flag)
        else $error("mask and flags both set");

    // Full input stage blocked only when result stalls
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("ready dropped without stall");
endmodule

// ----- src/sse_lane_cmp.sv -----
// One float32 lane compare: unordered, less, equal.
// Depends on sse_pkg.
`timescale 1ns / 1ps
module sse_lane_cmp
    import sse_pkg::*;
(
    input  lane_t x,
    input  lane_t y,
    output cmp_t  res
);
    logic [30:0] mx, my;
    logic        sx, sy, both_zero, mag_lt;

    always_comb begin
        mx = x[30:0];
        my = y[30:0];
        sx = x[31];
        sy = y[31];
        both_zero = (mx == 31'd0) && (my == 31'd0);
        mag_lt = mx < my;
        res.un = ((x & LANE_MAG) > LANE_INF) || ((y & LANE_MAG) > LANE_INF);
        res.eq = both_zero || (x == y);
        if (both_zero || x == y) begin
            res.lt = 1'b0;
        end else if (sx != sy) begin
            res.lt = sx;
        end else if (!sx) begin
            res.lt = mag_lt;
        end else begin
            res.lt = !mag_lt;
        end
    end
endmodule

// ----- src/sse_exec.sv -----
// Combinational datapath: compares, bitwise ops, shuffles, sign mask, flags.
// Depends on sse_pkg and sse_lane_cmp.
`timescale 1ns / 1ps
module sse_exec
    import sse_pkg::*;
(
    input  logic [3:0]  func,
    input  logic [7:0]  imm,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    output result_t     res
);
    lane_t a [4];
    lane_t b [4];
    lane_t r [4];
    cmp_t  c [4];
    logic  p [4];

    assign a[0] = a_low[31:0];
    assign a[1] = a_low[63:32];
    assign a[2] = a_high[31:0];
    assign a[3] = a_high[63:32];
    assign b[0] = b_low[31:0];
    assign b[1] = b_low[63:32];
    assign b[2] = b_high[31:0];
    assign b[3] = b_high[63:32];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        sse_lane_cmp u_cmp (.x(a[g]), .y(b[g]), .res(c[g]));
        always_comb begin
            unique case (pred_t'(imm[2:0]))
                PR_EQ:    p[g] = !c[g].un && c[g].eq;
                PR_LT:    p[g] = !c[g].un && c[g].lt;
                PR_LE:    p[g] = !c[g].un && (c[g].lt || c[g].eq);
                PR_UNORD: p[g] = c[g].un;
                PR_NEQ:   p[g] = c[g].un || !c[g].eq;
                PR_NLT:   p[g] = c[g].un || !c[g].lt;
                PR_NLE:   p[g] = c[g].un || !(c[g].lt || c[g].eq);
                PR_ORD:   p[g] = !c[g].un;
                default:  p[g] = 1'b0;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) r[i] = '0;
        res = '0;
        unique case (func)
            FN_CMPPS: begin
                for (int i = 0; i < 4; i++) r[i] = p[i] ? LANE_ONES : '0;
            end
            FN_CMPSS: begin
                r[0] = p[0] ? LANE_ONES : '0;
                r[1] = a[1];
                r[2] = a[2];
                r[3] = a[3];
            end
            FN_COMISS, FN_UCOMISS: begin
                res.zero_flag   = c[0].un || c[0].eq;
                res.parity_flag = c[0].un;
                res.carry_flag  = c[0].un || c[0].lt;
            end
            FN_AND:  for (int i = 0; i < 4; i++) r[i] = a[i] & b[i];
            FN_ANDN: for (int i = 0; i < 4; i++) r[i] = ~a[i] & b[i];
            FN_OR:   for (int i = 0; i < 4; i++) r[i] = a[i] | b[i];
            FN_XOR:  for (int i = 0; i < 4; i++) r[i] = a[i] ^ b[i];
            FN_SHUF: begin
                r[0] = a[imm[1:0] & SEL_MASK];
                r[1] = a[imm[3:2]];
                r[2] = b[imm[5:4]];
                r[3] = b[imm[7:6]];
            end
            FN_UNPCKL: begin r[0] = a[0]; r[1] = b[0]; r[2] = a[1]; r[3] = b[1]; end
            FN_UNPCKH: begin r[0] = a[2]; r[1] = b[2]; r[2] = a[3]; r[3] = b[3]; end
            FN_MOVMSK: begin
                for (int i = 0; i < 4; i++) res.sign_mask[i] = |(b[i] & LANE_SIGN);
            end
            FN_MOVHL: begin r[0] = b[2]; r[1] = b[3]; r[2] = a[2]; r[3] = a[3]; end
            FN_MOVLH: begin r[0] = a[0]; r[1] = a[1]; r[2] = b[0]; r[3] = b[1]; end
            FN_MOVSS: begin r[0] = b[0]; r[1] = a[1]; r[2] = a[2]; r[3] = a[3]; end
            default: ;
        endcase
        res.r_low  = {r[1], r[0]};
        res.r_high = {r[3], r[2]};
    end
endmodule
